// ----- hw/rtl/jtme_pkg.sv -----
// Shared types, codes and helpers of the joystick to mouse event converter.
package jtme_pkg;

   localparam int KEY_FIELDS  = 4;
   localparam int KEY_W       = 8;
   localparam int REG_COUNT   = 8;
   localparam int REG_IDX_W   = 3;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 56;
   localparam int MOVE_STEP   = 3;
   localparam int SPEED_START = 8;
   localparam int SPEED_DIV   = 6;
   localparam int SPEED_CAP   = 16;
   localparam int SPEED_TOP   = SPEED_CAP * SPEED_DIV;
   // 43/256 approximates 1/6 closely enough for counts below SPEED_TOP
   localparam int SPEED_RECIP = 43;

   localparam logic [REG_IDX_W-1:0] REG_UP     = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_DOWN   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_LEFT   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_RIGHT  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_BTN_A  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_ENTER  = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_START  = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_SELECT = 3'd7;

   typedef enum logic [1:0] {
      REQ_POLL       = 2'd0,
      REQ_MOUSE_READ = 2'd1,
      REQ_KEY_READ   = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_DATA    = 2'd0,
      ST_RETRY   = 2'd1,
      ST_RELEASE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      BTN_NONE = 2'd0,
      BTN_UP   = 2'd1,
      BTN_DOWN = 2'd2
   } button_type;

   typedef logic [REG_COUNT-1:0][KEY_W-1:0] cfg_regs_type;

   typedef struct packed {
      button_type         button;
      logic signed [6:0]  move_x;
      logic signed [6:0]  move_y;
   } event_type;

   localparam int EVENT_W = $bits(event_type);

   typedef struct packed {
      logic                            hit_select;
      logic                            nonzero;
      logic                            press;
      logic                            moved;
      event_type                       evt;
   } key_result_type;

   typedef struct packed {
      logic [4:0]                      pad;
      logic [KEY_FIELDS-1:0][KEY_W-1:0] keys;
      logic [2:0]                      key_count;
   } req_data_type;

   typedef struct packed {
      logic [3:0]                      pad;
      logic [KEY_FIELDS-1:0][KEY_W-1:0] keys;
      logic [2:0]                      held_count;
      logic signed [6:0]               move_y;
      logic signed [6:0]               move_x;
      button_type                      button;
      logic                            wake;
   } rsp_data_type;

   // Pointer step for one direction key: 3 times the acceleration factor.
   function automatic logic [5:0] move_amount(input logic [7:0] speed);
      logic [4:0]  factor;
      logic [12:0] prod;
      prod = 13'(speed[6:0]) * 13'(SPEED_RECIP);
      if (speed <= 8'(SPEED_START)) begin
         factor = 5'd1;
      end else if (speed >= 8'(SPEED_TOP)) begin
         factor = 5'(SPEED_CAP);
      end else begin
         factor = prod[12:8];
      end
      return 6'(factor) * 6'(MOVE_STEP);
   endfunction

endpackage

// ----- hw/rtl/joystick_to_mouse_event_converter.sv -----
// A poll goes through dispatch, a scan of the held codes on an empty poll, one post step,
// a step per reported code in mouse mode, then the result register; only an empty poll
// scans and only a non-empty one steps through codes. A read is answered from dispatch,
// or from a read step when the queue holds events. One item is in flight at a time; the
// shared key unit steps through one code per cycle.
// Reset clears mode, held codes, flags, counters and queue pointers at once; the event
// RAM is not cleared, its entries are only ever read after being written.
module joystick_to_mouse_event_converter #(
   parameter int QUEUE_DEPTH   = 64,
   parameter int KEYS_PER_POLL = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: key_count[2:0], key_a, key_b, key_c, key_d, zero pad
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [jtme_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: req_type[1:0]
   input  logic [1:0]                          req_tuser,
   // rsp_tdata: wake, button[1:0], move_x[6:0], move_y[6:0], held_count[2:0],
   //            out_key_a, out_key_b, out_key_c, out_key_d, zero pad
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [jtme_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // rsp_tuser: status[1:0]
   output logic [1:0]                          rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [jtme_pkg::REG_IDX_W-1:0]      csr_index,
   input  logic [jtme_pkg::KEY_W-1:0]          csr_wdata
);

   import jtme_pkg::*;

   localparam int KEY_LIMIT = (KEYS_PER_POLL < KEY_FIELDS) ? KEYS_PER_POLL : KEY_FIELDS;
   localparam int ADDR_W    = $clog2(QUEUE_DEPTH);
   localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_POST,
      S_MOUSE,
      S_READ,
      S_RESP
   } state_type;

   state_type                        state_ff, state_in;
   req_kind_type                     req_type_ff, req_type_in;
   logic [2:0]                       n_ff, n_in;
   logic [KEY_FIELDS-1:0][KEY_W-1:0] keys_ff, keys_in;
   logic [1:0]                       idx_ff, idx_in;
   logic [KEY_FIELDS-1:0][KEY_W-1:0] held_ff, held_in;
   logic [2:0]                       held_valid_ff, held_valid_in;
   logic                             release_ff, release_in;
   logic                             press_ff, press_in;
   logic                             mouse_ff, mouse_in;
   logic [7:0]                       speed_ff, speed_in;
   logic [FILL_W-1:0]                fill_ff, fill_in;
   logic [ADDR_W-1:0]                read_ff, read_in;
   logic                             moved_ff, moved_in;
   logic                             wake_ff, wake_in;
   cfg_regs_type                     regs_ff, regs_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   status_type                       rsp_status_ff, rsp_status_in;
   rsp_data_type                     rsp_data_ff, rsp_data_in;

   req_data_type                     req_data;
   logic [2:0]                       req_count;
   logic [7:0]                       unit_key;
   key_result_type                   unit_res;
   logic [5:0]                       amount;
   logic                             slot_free;
   logic                             push_en;
   event_type                        push_evt;
   logic                             ram_we;
   logic [ADDR_W-1:0]                ram_waddr;
   event_type                        ram_rdata;
   logic [EVENT_W-1:0]               ram_rdata_bits;
   logic [FILL_W-1:0]                read_next;
   logic                             moved_now;

   assign req_data   = req_data_type'(req_tdata);
   assign req_count  = (req_data.key_count > 3'(KEY_LIMIT)) ? 3'(KEY_LIMIT)
                                                             : req_data.key_count;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign amount     = move_amount(speed_ff);
   assign unit_key   = (state_ff == S_SCAN) ? held_ff[idx_ff] : keys_ff[idx_ff];
   assign read_next  = FILL_W'(read_ff) + FILL_W'(1);
   assign ram_rdata  = event_type'(ram_rdata_bits);

   jtme_key_unit u_key_unit (
      .key    (unit_key),
      .regs   (regs_ff),
      .amount (amount),
      .result (unit_res)
   );

   jtme_ram #(
      .WIDTH (EVENT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (push_evt),
      .rd_addr (read_ff),
      .rd_data (ram_rdata_bits)
   );

   // Queue write: a full queue drops moves and overwrites its newest entry with buttons.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = fill_ff[ADDR_W-1:0];
      if (push_en) begin
         if (fill_ff == FILL_W'(QUEUE_DEPTH)) begin
            ram_we    = (push_evt.button != BTN_NONE);
            ram_waddr = ADDR_W'(QUEUE_DEPTH - 1);
         end else begin
            ram_we = 1'b1;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_type_in   = req_type_ff;
      n_in          = n_ff;
      keys_in       = keys_ff;
      idx_in        = idx_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      release_in    = release_ff;
      press_in      = press_ff;
      mouse_in      = mouse_ff;
      speed_in      = speed_ff;
      fill_in       = fill_ff;
      read_in       = read_ff;
      moved_in      = moved_ff;
      wake_in       = wake_ff;
      regs_in       = regs_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      push_en       = 1'b0;
      push_evt      = '0;
      moved_now     = moved_ff;

      if (csr_valid) begin
         regs_in[csr_index] = csr_wdata;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (push_en) begin
         fill_in = fill_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               req_type_in = req_kind_type'(req_tuser);
               n_in        = req_count;
               keys_in     = req_data.keys;
               idx_in      = '0;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (req_type_ff)
               REQ_POLL: begin
                  if (n_ff == '0) begin
                     state_in = S_SCAN;
                  end else begin
                     for (int i = 0; i < KEY_FIELDS; i++) begin
                        if (3'(i) < n_ff) begin
                           held_in[i] = keys_ff[i];
                        end
                     end
                     state_in = S_POST;
                  end
               end
               REQ_MOUSE_READ: begin
                  if (FILL_W'(read_ff) < fill_ff) begin
                     state_in = S_READ;
                  end else if (slot_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_RETRY;
                     rsp_data_in   = '0;
                     state_in      = S_IDLE;
                  end
               end
               REQ_KEY_READ: begin
                  if (slot_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                     if (held_valid_ff != '0) begin
                        rsp_status_in          = ST_DATA;
                        rsp_data_in.held_count = held_valid_ff;
                        for (int i = 0; i < KEY_FIELDS; i++) begin
                           if (3'(i) < held_valid_ff) begin
                              rsp_data_in.keys[i] = held_ff[i];
                           end
                        end
                     end else if (release_ff) begin
                        release_in    = 1'b0;
                        rsp_status_in = ST_RELEASE;
                     end else begin
                        rsp_status_in = ST_RETRY;
                     end
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  if (slot_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_RETRY;
                     rsp_data_in   = '0;
                     state_in      = S_IDLE;
                  end
               end
            endcase
         end
         S_SCAN: begin
            // release scan over held codes; a held SELECT toggles the mode and stops it
            if (unit_res.nonzero) begin
               release_in = 1'b1;
            end
            if (unit_res.hit_select) begin
               mouse_in   = !mouse_ff;
               release_in = 1'b0;
            end
            if (unit_res.hit_select || idx_ff == 2'(KEY_LIMIT - 1)) begin
               held_in  = '0;
               state_in = S_POST;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         S_POST: begin
            idx_in   = '0;
            moved_in = 1'b0;
            if (mouse_ff) begin
               held_valid_in = '0;
               if (n_ff == '0) begin
                  wake_in  = press_ff;
                  speed_in = '0;
                  if (press_ff) begin
                     press_in        = 1'b0;
                     push_en         = 1'b1;
                     push_evt.button = BTN_UP;
                  end
                  state_in = S_RESP;
               end else begin
                  state_in = S_MOUSE;
               end
            end else begin
               held_valid_in = n_ff;
               wake_in       = (n_ff != '0) || release_ff;
               state_in      = S_RESP;
            end
         end
         S_MOUSE: begin
            if (unit_res.nonzero) begin
               push_en   = 1'b1;
               push_evt  = unit_res.evt;
               moved_now = moved_ff || unit_res.moved;
               if (unit_res.press) begin
                  press_in = 1'b1;
               end
            end else if (press_ff) begin
               press_in        = 1'b0;
               push_en         = 1'b1;
               push_evt.button = BTN_UP;
            end
            if (3'(idx_ff) == n_ff - 3'd1) begin
               wake_in = 1'b1;
               if (moved_now) begin
                  if (speed_ff != 8'hFF) begin
                     speed_in = speed_ff + 8'd1;
                  end
               end else begin
                  speed_in = '0;
               end
               state_in = S_RESP;
            end else begin
               idx_in   = idx_ff + 2'd1;
               moved_in = moved_now;
            end
         end
         S_READ: begin
            if (slot_free) begin
               rsp_valid_in        = 1'b1;
               rsp_status_in       = ST_DATA;
               rsp_data_in         = '0;
               rsp_data_in.button  = ram_rdata.button;
               rsp_data_in.move_x  = ram_rdata.move_x;
               rsp_data_in.move_y  = ram_rdata.move_y;
               // drained queue: both pointers return to the start
               if (read_next >= fill_ff) begin
                  read_in = '0;
                  fill_in = '0;
               end else begin
                  read_in = read_next[ADDR_W-1:0];
               end
               state_in = S_IDLE;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_status_in    = ST_DATA;
               rsp_data_in      = '0;
               rsp_data_in.wake = wake_ff;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (push_en && fill_ff != FILL_W'(QUEUE_DEPTH)) begin
         fill_in = fill_ff + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         held_ff       <= '0;
         held_valid_ff <= '0;
         release_ff    <= 1'b0;
         press_ff      <= 1'b0;
         mouse_ff      <= 1'b0;
         speed_ff      <= '0;
         fill_ff       <= '0;
         read_ff       <= '0;
         regs_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         release_ff    <= release_in;
         press_ff      <= press_in;
         mouse_ff      <= mouse_in;
         speed_ff      <= speed_in;
         fill_ff       <= fill_in;
         read_ff       <= read_in;
         regs_ff       <= regs_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_type_ff   <= req_type_in;
      n_ff          <= n_in;
      keys_ff       <= keys_in;
      idx_ff        <= idx_in;
      moved_ff      <= moved_in;
      wake_ff       <= wake_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(QUEUE_DEPTH))
      else $error("event queue fill beyond depth");

   a_read_behind_fill: assert property (@(posedge clock) disable iff (reset)
      (read_ff == '0) || (FILL_W'(read_ff) < fill_ff))
      else $error("read pointer not behind fill");

   a_empty_notice: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_RETRY || rsp_status_ff == ST_RELEASE)
      |-> rsp_data_ff == '0)
      else $error("retry or release beat carries data");

endmodule

// ----- hw/rtl/jtme_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module jtme_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/jtme_key_unit.sv -----
// Shared key unit: matches one key code against the code registers and forms its event.
module jtme_key_unit (
   input  logic [7:0]                    key,
   input  jtme_pkg::cfg_regs_type        regs,
   input  logic [5:0]                    amount,
   output jtme_pkg::key_result_type      result
);

   import jtme_pkg::*;

   logic signed [6:0] pos_mv;
   logic signed [6:0] neg_mv;

   assign pos_mv = $signed({1'b0, amount});
   assign neg_mv = -pos_mv;

   always_comb begin
      result            = '0;
      result.evt.button = BTN_NONE;
      result.nonzero    = (key != '0);
      result.hit_select = result.nonzero && (key == regs[REG_SELECT]);
      if (result.nonzero) begin
         // first match wins: up, down, left, right, then press codes
         if (key == regs[REG_UP]) begin
            result.evt.move_y = neg_mv;
            result.moved      = 1'b1;
         end else if (key == regs[REG_DOWN]) begin
            result.evt.move_y = pos_mv;
            result.moved      = 1'b1;
         end else if (key == regs[REG_LEFT]) begin
            result.evt.move_x = neg_mv;
            result.moved      = 1'b1;
         end else if (key == regs[REG_RIGHT]) begin
            result.evt.move_x = pos_mv;
            result.moved      = 1'b1;
         end else if (key == regs[REG_BTN_A] || key == regs[REG_ENTER] ||
                      key == regs[REG_START]) begin
            result.evt.button = BTN_DOWN;
            result.press      = 1'b1;
         end
      end
   end

endmodule
